>>> design/octant_circle_raster_core_macros.svh
// Assertion macros shared by the octant circle rasterizer RTL.
`ifndef OCTANT_CIRCLE_RASTER_CORE_MACROS_SVH
`define OCTANT_CIRCLE_RASTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is held.
`define OCR_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("octant circle raster check failed");

// Next-cycle implication, sampled on aclk, off while reset is held.
`define OCR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("octant circle raster check failed");

`endif

>>> design/octcr_pkg.sv
// Package: widths, constants, register indexes and the queued command type.
`timescale 1ns / 1ps
`default_nettype none

package octcr_pkg;

    // Field widths on the ports
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 6;
    localparam int COLOR_W  = 4;
    localparam int OUT_W    = 12;
    localparam int CANVAS_W = 11;
    localparam int MASK_W   = 8;

    // Internal widths, which hold radii up to 88; the 6-bit radius port allows at most 63
    localparam int RAD_W   = 7;
    localparam int LIM_W   = 6;
    localparam int TRACK_W = 12;

    // Parameter defaults
    localparam int MAX_RADIUS_DEF = 63;
    localparam int COORD_BITS_DEF = 10;

    // floor(r / sqrt 2) as r * 46341 >> 16
    localparam int                 SQRT_HALF_Q  = 16;
    localparam logic [SQRT_HALF_Q-1:0] SQRT_HALF_Q16 = 16'd46341;

    // Canvas bounds after reset
    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 11'd800;

    // Configuration register indexes
    localparam int                 CFG_IDX_W         = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

    // Command queue depth
    localparam int CMD_DEPTH = 2;

    // One classified circle request
    typedef struct packed {
        logic [CENTER_W-1:0] center_col;
        logic [CENTER_W-1:0] center_row;
        logic [RAD_W-1:0]    radius;
        logic [COLOR_W-1:0]  color;
        logic [LIM_W-1:0]    limit;
    } cmd_t;

    // Queue status seen by the front end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

>>> design/octcr_front.sv
// Front end: accepts requests, drops zero radius, saturates, computes octant length.
`timescale 1ns / 1ps
`default_nettype none

module octcr_front #(
    parameter int MAX_RADIUS = octcr_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = octcr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [octcr_pkg::CENTER_W-1:0]    s_center_col,
    input  wire logic [octcr_pkg::CENTER_W-1:0]    s_center_row,
    input  wire logic [octcr_pkg::RADIUS_W-1:0]    s_radius,
    input  wire logic [octcr_pkg::COLOR_W-1:0]     s_color,
    input  wire octcr_pkg::queue_stat_t            q_stat,
    output logic                                   push,
    output octcr_pkg::cmd_t                        push_cmd
);

    localparam int RAD_W  = octcr_pkg::RAD_W;
    localparam int PROD_W = RAD_W + octcr_pkg::SQRT_HALF_Q;
    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);
    localparam logic [octcr_pkg::CENTER_W-1:0] CMASK =
        octcr_pkg::CENTER_W'((1 << COORD_BITS) - 1);

    logic [RAD_W-1:0]  rad_ext;
    logic [RAD_W-1:0]  rad_sat;
    logic [PROD_W-1:0] prod;

    // Radius clamp and octant length
    assign rad_ext = {{(RAD_W - octcr_pkg::RADIUS_W){1'b0}}, s_radius};
    assign rad_sat = (rad_ext > RAD_MAX) ? RAD_MAX : rad_ext;
    assign prod    = PROD_W'(rad_sat) * PROD_W'(octcr_pkg::SQRT_HALF_Q16);

    // A word is taken whenever the queue has room; zero radius is dropped
    assign s_ready = !q_stat.full;
    assign push    = s_valid && s_ready && (rad_sat != '0);

    always_comb begin
        push_cmd.center_col = s_center_col & CMASK;
        push_cmd.center_row = s_center_row & CMASK;
        push_cmd.radius     = rad_sat;
        push_cmd.color      = s_color;
        push_cmd.limit      = prod[octcr_pkg::SQRT_HALF_Q +: octcr_pkg::LIM_W];
    end

endmodule

`default_nettype wire

>>> design/octcr_fifo.sv
// Short command queue between the front end and the step engine.
`timescale 1ns / 1ps
`default_nettype none

module octcr_fifo #(
    parameter int DEPTH = octcr_pkg::CMD_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire octcr_pkg::cmd_t      push_cmd,
    input  wire logic                 pop,
    output octcr_pkg::cmd_t           pop_cmd,
    output logic                      pop_valid,
    output octcr_pkg::queue_stat_t    q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    octcr_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_valid    = !q_stat.empty;
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/octcr_walk.sv
// Step engine: walks one octant per command and registers one result word per step.
`timescale 1ns / 1ps
`default_nettype none

module octcr_walk (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  pop_valid,
    input  wire octcr_pkg::cmd_t                       pop_cmd,
    output logic                                       pop,
    input  wire logic [octcr_pkg::CANVAS_W-1:0]        canvas_width,
    input  wire logic [octcr_pkg::CANVAS_W-1:0]        canvas_height,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_plus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_minus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_plus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_minus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_plus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_minus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_plus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_minus_y,
    output logic [octcr_pkg::MASK_W-1:0]               m_visible_mask,
    output logic [octcr_pkg::COLOR_W-1:0]              m_pixel_color,
    output logic                                       m_last_step
);

    localparam int OUT_W    = octcr_pkg::OUT_W;
    localparam int RAD_W    = octcr_pkg::RAD_W;
    localparam int LIM_W    = octcr_pkg::LIM_W;
    localparam int TRACK_W  = octcr_pkg::TRACK_W;
    localparam int CENTER_W = octcr_pkg::CENTER_W;

    // Point inside (0, width) x (0, height)
    function automatic logic seen(
        input logic signed [OUT_W-1:0]              col,
        input logic signed [OUT_W-1:0]              row,
        input logic [octcr_pkg::CANVAS_W-1:0]       w,
        input logic [octcr_pkg::CANVAS_W-1:0]       h
    );
        logic signed [OUT_W-1:0] ws;
        logic signed [OUT_W-1:0] hs;
        ws = $signed({1'b0, w});
        hs = $signed({1'b0, h});
        return (col > 0) && (col < ws) && (row > 0) && (row < hs);
    endfunction

    // Walk state
    logic                        busy_reg, busy_next;
    logic [LIM_W-1:0]            x_reg, x_next;
    logic [LIM_W-1:0]            lim_reg, lim_next;
    logic [RAD_W-1:0]            y_reg, y_next;
    logic signed [TRACK_W-1:0]   diff_reg, diff_next;
    logic signed [TRACK_W-1:0]   odd_reg, odd_next;
    logic [CENTER_W-1:0]         col_reg, col_next;
    logic [CENTER_W-1:0]         row_reg, row_next;
    logic [octcr_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                        m_valid_reg, m_valid_next;

    // Output word
    logic signed [OUT_W-1:0] cpx_reg, cmx_reg, cpy_reg, cmy_reg;
    logic signed [OUT_W-1:0] rpx_reg, rmx_reg, rpy_reg, rmy_reg;
    logic [octcr_pkg::MASK_W-1:0]  mask_reg;
    logic [octcr_pkg::COLOR_W-1:0] pcolor_reg;
    logic                          last_reg;

    logic                        advance;
    logic                        take;
    logic [RAD_W-1:0]            y_step;
    logic signed [TRACK_W-1:0]   odd_step;
    logic signed [TRACK_W-1:0]   diff_step;
    logic signed [TRACK_W-1:0]   x_track;
    logic signed [OUT_W-1:0]     cc, rr, xs, ys;
    logic signed [OUT_W-1:0]     cpx, cmx, cpy, cmy, rpx, rmx, rpy, rmy;
    logic [octcr_pkg::MASK_W-1:0] mask;

    assign pop     = !busy_reg && pop_valid;
    assign advance = busy_reg && (!m_valid_reg || m_ready);

    // One octant step: maybe drop y, then form the eight mirrored points
    always_comb begin
        take      = (diff_reg >= odd_reg);
        y_step    = take ? (y_reg - 1'b1) : y_reg;
        odd_step  = take ? (odd_reg - TRACK_W'(2)) : odd_reg;
        diff_step = take ? (diff_reg - odd_reg) : diff_reg;
        x_track   = $signed({{(TRACK_W - LIM_W){1'b0}}, x_reg});

        cc = $signed({{(OUT_W - CENTER_W){1'b0}}, col_reg});
        rr = $signed({{(OUT_W - CENTER_W){1'b0}}, row_reg});
        xs = $signed({{(OUT_W - LIM_W){1'b0}}, x_reg});
        ys = $signed({{(OUT_W - RAD_W){1'b0}}, y_step});

        cpx = cc + xs;
        cmx = cc - xs;
        cpy = cc + ys;
        cmy = cc - ys;
        rpx = rr + xs;
        rmx = rr - xs;
        rpy = rr + ys;
        rmy = rr - ys;

        mask[0] = seen(cpx, rpy, canvas_width, canvas_height);
        mask[1] = seen(cpx, rmy, canvas_width, canvas_height);
        mask[2] = seen(cmx, rpy, canvas_width, canvas_height);
        mask[3] = seen(cmx, rmy, canvas_width, canvas_height);
        mask[4] = seen(cpy, rpx, canvas_width, canvas_height);
        mask[5] = seen(cpy, rmx, canvas_width, canvas_height);
        mask[6] = seen(cmy, rpx, canvas_width, canvas_height);
        mask[7] = seen(cmy, rmx, canvas_width, canvas_height);
    end

    // Sequencer: load on pop, step while the output can take a word
    always_comb begin
        busy_next    = busy_reg;
        x_next       = x_reg;
        lim_next     = lim_reg;
        y_next       = y_reg;
        diff_next    = diff_reg;
        odd_next     = odd_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        color_next   = color_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop) begin
            busy_next  = 1'b1;
            x_next     = '0;
            lim_next   = pop_cmd.limit;
            y_next     = pop_cmd.radius;
            diff_next  = '0;
            odd_next   = $signed(TRACK_W'({pop_cmd.radius, 1'b0})) - TRACK_W'(1);
            col_next   = pop_cmd.center_col;
            row_next   = pop_cmd.center_row;
            color_next = pop_cmd.color;
        end else if (advance) begin
            m_valid_next = 1'b1;
            x_next       = x_reg + 1'b1;
            y_next       = y_step;
            odd_next     = odd_step;
            diff_next    = diff_step + (x_track <<< 1) - TRACK_W'(3);
            if (x_reg == lim_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        lim_reg   <= lim_next;
        y_reg     <= y_next;
        diff_reg  <= diff_next;
        odd_reg   <= odd_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
        color_reg <= color_next;
    end

    // Output word register
    always_ff @(posedge aclk) begin
        if (advance) begin
            cpx_reg    <= cpx;
            cmx_reg    <= cmx;
            cpy_reg    <= cpy;
            cmy_reg    <= cmy;
            rpx_reg    <= rpx;
            rmx_reg    <= rmx;
            rpy_reg    <= rpy;
            rmy_reg    <= rmy;
            mask_reg   <= mask;
            pcolor_reg <= color_reg;
            last_reg   <= (x_reg == lim_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_col_plus_x   = cpx_reg;
    assign m_col_minus_x  = cmx_reg;
    assign m_col_plus_y   = cpy_reg;
    assign m_col_minus_y  = cmy_reg;
    assign m_row_plus_x   = rpx_reg;
    assign m_row_minus_x  = rmx_reg;
    assign m_row_plus_y   = rpy_reg;
    assign m_row_minus_y  = rmy_reg;
    assign m_visible_mask = mask_reg;
    assign m_pixel_color  = pcolor_reg;
    assign m_last_step    = last_reg;

endmodule

`default_nettype wire

>>> design/octant_circle_raster_core.sv
// Top level: octant circle rasterizer with config registers, queue and step engine.
`timescale 1ns / 1ps
`default_nettype none

`include "octant_circle_raster_core_macros.svh"

// Octant circle rasterizer. Each request (center, radius, color) yields L+1 result
// words, L = floor(radius * 0.7071), one per octant step, each carrying the eight
// mirrored points, a canvas visibility mask, the color and a last-step flag. A zero
// radius is dropped with no output. The step engine produces one word per cycle
// while the output is taken, and a request first needs a load step, which yields no
// word; that single engine sets the throughput. A two-word command queue lets the
// next requests be taken while a circle is being walked. The canvas registers reset
// to 800 and should be written only while idle.
module octant_circle_raster_core #(
    parameter int MAX_RADIUS = octcr_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = octcr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // request channel
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [octcr_pkg::CENTER_W-1:0]        s_center_col,
    input  wire logic [octcr_pkg::CENTER_W-1:0]        s_center_row,
    input  wire logic [octcr_pkg::RADIUS_W-1:0]        s_radius,
    input  wire logic [octcr_pkg::COLOR_W-1:0]         s_color,
    // result channel
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_plus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_minus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_plus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_col_minus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_plus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_minus_x,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_plus_y,
    output logic signed [octcr_pkg::OUT_W-1:0]         m_row_minus_y,
    output logic [octcr_pkg::MASK_W-1:0]               m_visible_mask,
    output logic [octcr_pkg::COLOR_W-1:0]              m_pixel_color,
    output logic                                       m_last_step,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [octcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [octcr_pkg::CANVAS_W-1:0]        cfg_wdata
);

    logic [octcr_pkg::CANVAS_W-1:0] canvas_width_reg, canvas_width_next;
    logic [octcr_pkg::CANVAS_W-1:0] canvas_height_reg, canvas_height_next;

    octcr_pkg::queue_stat_t q_stat;
    octcr_pkg::cmd_t        push_cmd;
    octcr_pkg::cmd_t        pop_cmd;
    logic                   push;
    logic                   pop;
    logic                   pop_valid;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                octcr_pkg::REG_CANVAS_WIDTH:  canvas_width_next  = cfg_wdata;
                octcr_pkg::REG_CANVAS_HEIGHT: canvas_height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= octcr_pkg::CANVAS_RESET;
            canvas_height_reg <= octcr_pkg::CANVAS_RESET;
        end else begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
        end
    end

    // Front end
    octcr_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_center_col (s_center_col),
        .s_center_row (s_center_row),
        .s_radius     (s_radius),
        .s_color      (s_color),
        .q_stat       (q_stat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // Command queue
    octcr_fifo #(
        .DEPTH (octcr_pkg::CMD_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .pop_valid (pop_valid),
        .q_stat    (q_stat)
    );

    // Step engine
    octcr_walk u_walk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_cmd        (pop_cmd),
        .pop            (pop),
        .canvas_width   (canvas_width_reg),
        .canvas_height  (canvas_height_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_col_plus_x   (m_col_plus_x),
        .m_col_minus_x  (m_col_minus_x),
        .m_col_plus_y   (m_col_plus_y),
        .m_col_minus_y  (m_col_minus_y),
        .m_row_plus_x   (m_row_plus_x),
        .m_row_minus_x  (m_row_minus_x),
        .m_row_plus_y   (m_row_plus_y),
        .m_row_minus_y  (m_row_minus_y),
        .m_visible_mask (m_visible_mask),
        .m_pixel_color  (m_pixel_color),
        .m_last_step    (m_last_step)
    );

    // Checks
    `OCR_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
    `OCR_ASSERT_NOW(a_mirror_sum, m_valid, (m_col_plus_x + m_col_minus_x) == (m_col_plus_y + m_col_minus_y))
    `OCR_ASSERT_NOW(a_zero_width_mask, m_valid && (canvas_width_reg == '0), m_visible_mask == '0)
    `OCR_ASSERT_NEXT(a_step_follows, m_valid && m_ready && !m_last_step, m_valid)

endmodule

`default_nettype wire
